// ===== hw/rtl/dns_answer_record_walker_core_defines.svh =====
// Assertion macros used by the checker file of this block.
`ifndef DNS_ANSWER_RECORD_WALKER_CORE_DEFINES_SVH
`define DNS_ANSWER_RECORD_WALKER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define DNSARW_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dnsarw: same-cycle check failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define DNSARW_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dnsarw: next-cycle check failed");

`endif

// ===== hw/rtl/dnsarw_pkg.sv =====
`timescale 1ns / 1ps
package dnsarw_pkg;

	localparam logic       MODE_BEGIN = 1'b0;
	localparam logic       MODE_BYTE  = 1'b1;
	localparam logic [3:0] HDR_LEN    = 4'd12;
	localparam logic [15:0] A_DATA_LEN = 16'd4;
	localparam logic [15:0] TYPE_A     = 16'd1;
	localparam logic [15:0] BYTE_MAX   = 16'hFFFF;

	typedef struct packed {
		logic        mode;
		logic [7:0]  data_byte;
		logic [15:0] record_count;
	} item_t;

	typedef struct packed {
		logic [15:0] consumed_bytes;
		logic        found_a;
		logic [15:0] a_type;
		logic [15:0] a_class;
		logic [31:0] a_ttl;
		logic [15:0] a_rdlength;
		logic [31:0] a_address;
	} result_t;

endpackage

// ===== hw/rtl/dnsarw_walker.sv =====
`timescale 1ns / 1ps
module dnsarw_walker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  dnsarw_pkg::item_t   item,
	output logic                emit,
	output dnsarw_pkg::result_t res
);

	logic        active_q, active_d;
	logic [15:0] recs_left_q, recs_left_d;
	logic [3:0]  hoff_q, hoff_d;
	logic [15:0] dleft_q, dleft_d;
	logic [15:0] total_q, total_d;
	logic [15:0] cur_type_q, cur_type_d;
	logic [15:0] cur_class_q, cur_class_d;
	logic [31:0] cur_ttl_q, cur_ttl_d;
	logic [15:0] cur_rdlen_q, cur_rdlen_d;
	logic [31:0] addr_q, addr_d;
	logic [15:0] sv_type_q, sv_type_d;
	logic [15:0] sv_class_q, sv_class_d;
	logic [31:0] sv_ttl_q, sv_ttl_d;
	logic [15:0] sv_rdlen_q, sv_rdlen_d;
	logic [31:0] sv_addr_q, sv_addr_d;
	logic        seen_q, seen_d;

	always_comb begin
		logic end_rec;
		logic [7:0] b;
		end_rec     = 1'b0;
		b           = item.data_byte;
		emit        = 1'b0;
		active_d    = active_q;
		recs_left_d = recs_left_q;
		hoff_d      = hoff_q;
		dleft_d     = dleft_q;
		total_d     = total_q;
		cur_type_d  = cur_type_q;
		cur_class_d = cur_class_q;
		cur_ttl_d   = cur_ttl_q;
		cur_rdlen_d = cur_rdlen_q;
		addr_d      = addr_q;
		sv_type_d   = sv_type_q;
		sv_class_d  = sv_class_q;
		sv_ttl_d    = sv_ttl_q;
		sv_rdlen_d  = sv_rdlen_q;
		sv_addr_d   = sv_addr_q;
		seen_d      = seen_q;
		if (step && item.mode == dnsarw_pkg::MODE_BEGIN) begin
			recs_left_d = item.record_count;
			hoff_d      = '0;
			dleft_d     = '0;
			total_d     = '0;
			addr_d      = '0;
			sv_type_d   = '0;
			sv_class_d  = '0;
			sv_ttl_d    = '0;
			sv_rdlen_d  = '0;
			sv_addr_d   = '0;
			seen_d      = 1'b0;
			active_d    = (item.record_count != 16'd0);
			emit        = (item.record_count == 16'd0);
		end else if (step && active_q) begin
			if (total_q != dnsarw_pkg::BYTE_MAX) begin
				total_d = total_q + 16'd1;
			end
			if (hoff_q < dnsarw_pkg::HDR_LEN) begin
				case (hoff_q)
					4'd2, 4'd3: cur_type_d = {cur_type_q[7:0], b};
					4'd4, 4'd5: cur_class_d = {cur_class_q[7:0], b};
					4'd6, 4'd7, 4'd8, 4'd9: cur_ttl_d = {cur_ttl_q[23:0], b};
					4'd10, 4'd11: cur_rdlen_d = {cur_rdlen_q[7:0], b};
					default: ;
				endcase
				hoff_d = hoff_q + 4'd1;
				if (hoff_d == dnsarw_pkg::HDR_LEN) begin
					if (cur_type_d == dnsarw_pkg::TYPE_A) begin
						seen_d     = 1'b1;
						sv_type_d  = cur_type_d;
						sv_class_d = cur_class_d;
						sv_ttl_d   = cur_ttl_d;
						sv_rdlen_d = cur_rdlen_d;
						sv_addr_d  = '0;
						addr_d     = '0;
						dleft_d    = dnsarw_pkg::A_DATA_LEN;
					end else begin
						dleft_d = cur_rdlen_d;
					end
					end_rec = (dleft_d == 16'd0);
				end
			end else begin
				if (cur_type_q == dnsarw_pkg::TYPE_A) begin
					addr_d = {addr_q[23:0], b};
				end
				dleft_d = dleft_q - 16'd1;
				if (dleft_d == 16'd0) begin
					if (cur_type_q == dnsarw_pkg::TYPE_A) begin
						sv_addr_d = addr_d;
					end
					end_rec = 1'b1;
				end
			end
			if (end_rec) begin
				hoff_d      = '0;
				dleft_d     = '0;
				recs_left_d = recs_left_q - 16'd1;
				if (recs_left_d == 16'd0) begin
					active_d = 1'b0;
					emit     = 1'b1;
				end
			end
		end
		res.consumed_bytes = total_d;
		res.found_a        = seen_d;
		res.a_type         = sv_type_d;
		res.a_class        = sv_class_d;
		res.a_ttl          = sv_ttl_d;
		res.a_rdlength     = sv_rdlen_d;
		res.a_address      = sv_addr_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			recs_left_q <= '0;
			hoff_q      <= '0;
			dleft_q     <= '0;
			total_q     <= '0;
			cur_type_q  <= '0;
			cur_class_q <= '0;
			cur_ttl_q   <= '0;
			cur_rdlen_q <= '0;
			addr_q      <= '0;
			sv_type_q   <= '0;
			sv_class_q  <= '0;
			sv_ttl_q    <= '0;
			sv_rdlen_q  <= '0;
			sv_addr_q   <= '0;
			seen_q      <= 1'b0;
		end else begin
			active_q    <= active_d;
			recs_left_q <= recs_left_d;
			hoff_q      <= hoff_d;
			dleft_q     <= dleft_d;
			total_q     <= total_d;
			cur_type_q  <= cur_type_d;
			cur_class_q <= cur_class_d;
			cur_ttl_q   <= cur_ttl_d;
			cur_rdlen_q <= cur_rdlen_d;
			addr_q      <= addr_d;
			sv_type_q   <= sv_type_d;
			sv_class_q  <= sv_class_d;
			sv_ttl_q    <= sv_ttl_d;
			sv_rdlen_q  <= sv_rdlen_d;
			sv_addr_q   <= sv_addr_d;
			seen_q      <= seen_d;
		end
	end

endmodule

// ===== hw/rtl/dns_answer_record_walker_core.sv =====
`timescale 1ns / 1ps
// Walks the answer section of a DNS message one byte per request.
// Input channel: item_valid, item_stall and item. A request with mode zero
// starts a section of record_count records; a request with mode one carries
// the next byte of the section. Bytes outside an active section are dropped.
// Output channel: result_valid, result_stall and result. One result leaves
// after the last byte of the last record, or at once for an empty section,
// with the byte count and the fields of the last A record.
// An accepted request is held in the input register while the walker updates the
// record state from it, and the result is then written to the two-entry queue,
// from which the receiver may take it. Throughput is one request per cycle while
// item_stall is low; the walker takes a request whenever the queue has room or
// is being read.
// While the receiver stalls, results wait in the two-entry queue and requests
// are still taken; item_stall rises once the queue is full and the receiver
// still stalls, whether or not the request in the input register would give
// a further result.
// Reset clears the section state, the captured record and the queue.
module dns_answer_record_walker_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  dnsarw_pkg::item_t   item,
	output logic                result_valid,
	input  logic                result_stall,
	output dnsarw_pkg::result_t result
);

	logic                item_valid_s1;
	dnsarw_pkg::item_t   item_s1;
	logic [1:0]          res_cnt_q;
	dnsarw_pkg::result_t res0_q, res1_q;
	logic                fire, pop, push, emit;
	dnsarw_pkg::result_t res;

	assign pop          = result_valid && !result_stall;
	assign fire         = item_valid_s1 && (res_cnt_q != 2'd2 || pop);
	assign item_stall   = item_valid_s1 && !fire;
	assign push         = fire && emit;
	assign result_valid = (res_cnt_q != 2'd0);
	assign result       = res0_q;

	dnsarw_walker u_walker (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (fire),
		.item   (item_s1),
		.emit   (emit),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (item_valid && !item_stall) begin
			item_valid_s1 <= 1'b1;
		end else if (fire) begin
			item_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_cnt_q <= '0;
		end else if (push && !pop) begin
			res_cnt_q <= res_cnt_q + 2'd1;
		end else if (pop && !push) begin
			res_cnt_q <= res_cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push && pop) begin
			if (res_cnt_q == 2'd1) begin
				res0_q <= res;
			end else begin
				res0_q <= res1_q;
				res1_q <= res;
			end
		end else if (pop) begin
			res0_q <= res1_q;
		end else if (push) begin
			if (res_cnt_q == 2'd0) begin
				res0_q <= res;
			end else begin
				res1_q <= res;
			end
		end
	end

endmodule

// ===== hw/rtl/dnsarw_checker.sv =====
`timescale 1ns / 1ps
`include "dns_answer_record_walker_core_defines.svh"
module dnsarw_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                item_stall,
	input logic                result_valid,
	input logic                result_stall,
	input dnsarw_pkg::result_t result
);

	`DNSARW_ASSERT_NXT(a_result_held, result_valid && result_stall, result_valid)
	`DNSARW_ASSERT_NXT(a_result_stable, result_valid && result_stall, $stable(result))
	`DNSARW_ASSERT_NOW(a_no_a_zero, result_valid && !result.found_a, result.a_type == 16'd0 && result.a_class == 16'd0 && result.a_ttl == 32'd0 && result.a_rdlength == 16'd0 && result.a_address == 32'd0)
	`DNSARW_ASSERT_NOW(a_found_type, result_valid && result.found_a, result.a_type == dnsarw_pkg::TYPE_A)
	`DNSARW_ASSERT_NOW(a_stall_full, item_stall, result_valid && result_stall)

endmodule

bind dns_answer_record_walker_core dnsarw_checker u_dnsarw_checker (.*);

// ===== tb/dns_answer_record_walker_core_tb.sv =====
`timescale 1ns / 1ps
module dns_answer_record_walker_core_tb;

	localparam int RANDOM_ITEMS = 1700;
	localparam int STALL_LIMIT  = 3000;
	localparam int HOLD_OFF     = 400;
	localparam int DIR_ROWS     = 22;

	localparam logic [15:0] RR_NS    = 16'd2;
	localparam logic [15:0] RR_CNAME = 16'd5;
	localparam logic [15:0] RR_MX    = 16'd15;
	localparam logic [15:0] RR_TXT   = 16'd16;
	localparam logic [15:0] RR_AAAA  = 16'd28;

	localparam dnsarw_pkg::result_t NO_RECORDS = '0;
	localparam logic [$bits(dnsarw_pkg::result_t):0] UNTYPED = '0;

	typedef struct packed {
		dnsarw_pkg::item_t   req;
		logic                typed;
		dnsarw_pkg::result_t answer;
	} row_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                item_valid = 1'b0;
	logic                item_stall;
	dnsarw_pkg::item_t   item = '0;
	logic                result_valid;
	logic                result_stall = 1'b0;
	dnsarw_pkg::result_t result;

	row_t                directed_rows [DIR_ROWS];
	row_t                plan[$];
	row_t                on_bus = '0;
	dnsarw_pkg::result_t answers_due[$];
	int                  mismatches = 0;
	int                  reqs_taken = 0;
	int                  live_items = 0;
	int                  idle_cycles = 0;

	logic        sect_open = 1'b0;
	logic [15:0] recs_left = '0;
	logic [3:0]  hdr_pos = '0;
	logic [15:0] data_left = '0;
	logic [15:0] byte_cnt = '0;
	logic [15:0] rr_type = '0;
	logic [15:0] rr_class = '0;
	logic [31:0] rr_ttl = '0;
	logic [15:0] rr_rdlen = '0;
	logic [31:0] addr_acc = '0;
	logic        cap_valid = 1'b0;
	logic [15:0] cap_type = '0;
	logic [15:0] cap_class = '0;
	logic [31:0] cap_ttl = '0;
	logic [15:0] cap_rdlen = '0;
	logic [31:0] cap_addr = '0;

	dns_answer_record_walker_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic logic walk_request(input dnsarw_pkg::item_t req,
		output dnsarw_pkg::result_t summary);
		logic done;
		logic rec_end;
		done = 1'b0;
		rec_end = 1'b0;
		summary = '0;
		if (req.mode == dnsarw_pkg::MODE_BEGIN) begin
			recs_left = req.record_count;
			hdr_pos = '0;
			data_left = '0;
			byte_cnt = '0;
			addr_acc = '0;
			cap_valid = 1'b0;
			cap_type = '0;
			cap_class = '0;
			cap_ttl = '0;
			cap_rdlen = '0;
			cap_addr = '0;
			sect_open = (recs_left != 16'd0);
			done = (recs_left == 16'd0);
		end else if (sect_open) begin
			if (byte_cnt != dnsarw_pkg::BYTE_MAX)
				byte_cnt = byte_cnt + 16'd1;
			if (hdr_pos < dnsarw_pkg::HDR_LEN) begin
				case (hdr_pos)
				4'd2, 4'd3: rr_type = {rr_type[7:0], req.data_byte};
				4'd4, 4'd5: rr_class = {rr_class[7:0], req.data_byte};
				4'd6, 4'd7, 4'd8, 4'd9: rr_ttl = {rr_ttl[23:0], req.data_byte};
				4'd10, 4'd11: rr_rdlen = {rr_rdlen[7:0], req.data_byte};
				default: ;
				endcase
				hdr_pos = hdr_pos + 4'd1;
				if (hdr_pos == dnsarw_pkg::HDR_LEN) begin
					if (rr_type == dnsarw_pkg::TYPE_A) begin
						cap_valid = 1'b1;
						cap_type = rr_type;
						cap_class = rr_class;
						cap_ttl = rr_ttl;
						cap_rdlen = rr_rdlen;
						cap_addr = '0;
						addr_acc = '0;
						data_left = dnsarw_pkg::A_DATA_LEN;
					end else begin
						data_left = rr_rdlen;
					end
					rec_end = (data_left == 16'd0);
				end
			end else begin
				if (rr_type == dnsarw_pkg::TYPE_A)
					addr_acc = {addr_acc[23:0], req.data_byte};
				data_left = data_left - 16'd1;
				if (data_left == 16'd0) begin
					if (rr_type == dnsarw_pkg::TYPE_A)
						cap_addr = addr_acc;
					rec_end = 1'b1;
				end
			end
			if (rec_end) begin
				hdr_pos = '0;
				data_left = '0;
				recs_left = recs_left - 16'd1;
				if (recs_left == 16'd0) begin
					sect_open = 1'b0;
					done = 1'b1;
				end
			end
		end
		if (done)
			summary = {byte_cnt, cap_valid, cap_type, cap_class, cap_ttl, cap_rdlen, cap_addr};
		return done;
	endfunction

	task automatic flag_error(input string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s", $time, msg);
	endtask

	task automatic check_result(input dnsarw_pkg::result_t got);
		dnsarw_pkg::result_t want;
		string               bad;
		if (answers_due.size() == 0) begin
			flag_error($sformatf("result %h arrived with none outstanding", got));
			return;
		end
		want = answers_due.pop_front();
		bad = "";
		if (got.consumed_bytes !== want.consumed_bytes) bad = {bad, " consumed_bytes"};
		if (got.found_a !== want.found_a) bad = {bad, " found_a"};
		if (got.a_type !== want.a_type) bad = {bad, " a_type"};
		if (got.a_class !== want.a_class) bad = {bad, " a_class"};
		if (got.a_ttl !== want.a_ttl) bad = {bad, " a_ttl"};
		if (got.a_rdlength !== want.a_rdlength) bad = {bad, " a_rdlength"};
		if (got.a_address !== want.a_address) bad = {bad, " a_address"};
		if (bad != "")
			flag_error($sformatf("mismatch in%s: expected %h, got %h", bad, want, got));
	endtask

	task automatic put(input dnsarw_pkg::item_t req);
		plan.push_back({req, UNTYPED});
	endtask

	task automatic put_byte(input logic [7:0] b);
		put({dnsarw_pkg::MODE_BYTE, b, 16'($urandom)});
		live_items++;
	endtask

	task automatic put_begin(input logic [15:0] count);
		put({dnsarw_pkg::MODE_BEGIN, 8'($urandom), count});
		live_items++;
	endtask

	task automatic put_record(input logic [15:0] rtype, input logic [15:0] rdlen);
		int          n;
		logic [15:0] rclass;
		logic [31:0] ttl;
		n = (rtype == dnsarw_pkg::TYPE_A) ? int'(dnsarw_pkg::A_DATA_LEN) : int'(rdlen);
		rclass = ($urandom_range(3) == 0) ? 16'($urandom) : 16'h0001;
		ttl = $urandom;
		put_byte(($urandom_range(3) == 0) ? 8'($urandom) : 8'hC0);
		put_byte(8'($urandom));
		put_byte(rtype[15:8]);
		put_byte(rtype[7:0]);
		put_byte(rclass[15:8]);
		put_byte(rclass[7:0]);
		put_byte(ttl[31:24]);
		put_byte(ttl[23:16]);
		put_byte(ttl[15:8]);
		put_byte(ttl[7:0]);
		put_byte(rdlen[15:8]);
		put_byte(rdlen[7:0]);
		repeat (n) put_byte(8'($urandom));
	endtask

	task automatic put_random_record();
		logic [15:0] rtype;
		logic [15:0] rdlen;
		case ($urandom_range(9))
		0, 1, 2, 3: rtype = dnsarw_pkg::TYPE_A;
		4: rtype = 16'($urandom);
		5: rtype = RR_CNAME;
		6: rtype = RR_AAAA;
		7: rtype = RR_MX;
		8: rtype = RR_NS;
		default: rtype = RR_TXT;
		endcase
		if (rtype == dnsarw_pkg::TYPE_A)
			rdlen = ($urandom_range(1) == 0) ? dnsarw_pkg::A_DATA_LEN : 16'($urandom);
		else if ($urandom_range(7) == 0)
			rdlen = 16'($urandom_range(9, 40));
		else
			rdlen = 16'($urandom_range(0, 8));
		put_record(rtype, rdlen);
	endtask

	always @(posedge clk) begin : monitor
		dnsarw_pkg::result_t summary;
		logic                produced;
		if (arst_n) begin
			if (item_valid && !item_stall) begin
				reqs_taken++;
				produced = walk_request(on_bus.req, summary);
				if (on_bus.typed)
					answers_due.push_back(on_bus.answer);
				else if (produced)
					answers_due.push_back(summary);
			end
			if (result_valid && !result_stall)
				check_result(result);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("dns_answer_record_walker_core_tb: FAIL");
				$finish;
			end
		end
	end

	initial begin : receiver
		int pattern;
		int span;
		bit held;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			pattern = $urandom_range(3);
			span = $urandom_range(20, 300);
			if (!held && reqs_taken >= 400) begin
				held = 1'b1;
				@(posedge clk);
				result_stall <= 1'b1;
				repeat (HOLD_OFF - 1) @(posedge clk);
			end
			for (int c = 0; c < span; c++) begin
				@(posedge clk);
				case (pattern)
				0: result_stall <= 1'b0;
				1: result_stall <= ($urandom_range(1) == 0);
				2: result_stall <= ($urandom_range(3) != 0);
				default: result_stall <= (c % 3 == 0);
				endcase
			end
		end
	end

	initial begin : sender
		int target;
		int pick;
		int n_recs;
		int cut;
		int burst_left;
		int gap;

		// An idle byte, an empty section, a section dropped by a new begin, then one
		// A record with extreme header fields, and a stray byte once it is done.
		directed_rows = '{
			{dnsarw_pkg::MODE_BYTE,  8'hFF, 16'hFFFF, UNTYPED},
			{dnsarw_pkg::MODE_BEGIN, 8'hFF, 16'h0000, 1'b1, NO_RECORDS},
			{dnsarw_pkg::MODE_BEGIN, 8'h00, 16'hFFFF, UNTYPED},
			{dnsarw_pkg::MODE_BYTE,  8'h12, 16'h0000, UNTYPED},
			{dnsarw_pkg::MODE_BEGIN, 8'h5A, 16'h0001, UNTYPED},
			{dnsarw_pkg::MODE_BYTE,  8'hC0, 16'hFFFF, UNTYPED},
			{dnsarw_pkg::MODE_BYTE,  8'h0C, 16'h0000, UNTYPED},
			{dnsarw_pkg::MODE_BYTE,  8'h00, 16'hFFFF, UNTYPED},
			{dnsarw_pkg::MODE_BYTE,  8'h01, 16'h0000, UNTYPED},
			{dnsarw_pkg::MODE_BYTE,  8'h00, 16'hFFFF, UNTYPED},
			{dnsarw_pkg::MODE_BYTE,  8'h01, 16'h0000, UNTYPED},
			{dnsarw_pkg::MODE_BYTE,  8'hFF, 16'hFFFF, UNTYPED},
			{dnsarw_pkg::MODE_BYTE,  8'hFF, 16'h0000, UNTYPED},
			{dnsarw_pkg::MODE_BYTE,  8'hFF, 16'hFFFF, UNTYPED},
			{dnsarw_pkg::MODE_BYTE,  8'hFF, 16'h0000, UNTYPED},
			{dnsarw_pkg::MODE_BYTE,  8'h00, 16'hFFFF, UNTYPED},
			{dnsarw_pkg::MODE_BYTE,  8'h04, 16'h0000, UNTYPED},
			{dnsarw_pkg::MODE_BYTE,  8'hC0, 16'hFFFF, UNTYPED},
			{dnsarw_pkg::MODE_BYTE,  8'hA8, 16'h0000, UNTYPED},
			{dnsarw_pkg::MODE_BYTE,  8'h00, 16'hFFFF, UNTYPED},
			{dnsarw_pkg::MODE_BYTE,  8'hFF, 16'h0000, 1'b1, 16'd16, 1'b1,
				dnsarw_pkg::TYPE_A, 16'h0001, 32'hFFFF_FFFF, 16'h0004, 32'hC0A8_00FF},
			{dnsarw_pkg::MODE_BYTE,  8'h00, 16'hFFFF, UNTYPED}
		};
		foreach (directed_rows[i])
			plan.push_back(directed_rows[i]);

		put_begin(16'd2);
		put_record(RR_AAAA, 16'd0);
		put_record(RR_CNAME, 16'd3);

		target = live_items + RANDOM_ITEMS;
		while (live_items < target) begin
			pick = $urandom_range(99);
			if (pick < 8) begin
				repeat ($urandom_range(1, 4))
					put({dnsarw_pkg::MODE_BYTE, 8'($urandom), 16'($urandom)});
			end else if (pick < 12) begin
				put_begin(16'd0);
			end else if (pick < 25) begin
				put_begin(($urandom_range(1) == 0) ? 16'($urandom) : 16'($urandom_range(2, 5)));
				repeat ($urandom_range(0, 2)) put_random_record();
				cut = $urandom_range(0, 6);
				while (cut > 0 && plan[$].req.mode == dnsarw_pkg::MODE_BYTE) begin
					void'(plan.pop_back());
					live_items--;
					cut--;
				end
			end else begin
				n_recs = $urandom_range(1, 4);
				put_begin(16'(n_recs));
				repeat (n_recs) put_random_record();
			end
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		burst_left = 0;
		for (int idx = 0; idx < plan.size(); idx++) begin
			if (burst_left == 0) begin
				burst_left = ($urandom_range(9) == 0) ? $urandom_range(200, 600)
					: $urandom_range(1, 30);
				gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
				if (gap > 0) begin
					item_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			burst_left--;
			item_valid <= 1'b1;
			item <= plan[idx].req;
			on_bus <= plan[idx];
			@(posedge clk);
			while (item_stall) @(posedge clk);
		end
		item_valid <= 1'b0;

		while (answers_due.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("dns_answer_record_walker_core_tb: PASS");
		else
			$display("dns_answer_record_walker_core_tb: FAIL");
		$finish;
	end

endmodule
